FILE: sv/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Holds the calibration and stage types, register indexes and fixed widths.
// No dependencies; every other file imports it.
package bpc_pkg;

  // Register stages from input to result register.
  localparam int NUM_STAGES = 10;

  // Stage positions in the load vector.
  localparam int STG_DT     = 0;
  localparam int STG_MUL1   = 1;
  localparam int STG_FIRST  = 2;
  localparam int STG_SQUARE = 3;
  localparam int STG_CORR   = 4;
  localparam int STG_APPLY  = 5;
  localparam int STG_PPROD  = 6;
  localparam int STG_PSUM   = 7;
  localparam int STG_PRES   = 8;
  localparam int STG_CLAMP  = 9;

  // Widths of the fixed fields and of the internal values.
  localparam int CAL_W   = 16;
  localparam int RAW_W   = 24;
  localparam int DT_W    = 25;
  localparam int TEMP1_W = 19;
  localparam int TEMP2_W = 20;
  localparam int T2_W    = 18;
  localparam int SQ_W    = 36;
  localparam int CORR_W  = 38;
  localparam int OFF_W   = 40;
  localparam int SENS_W  = 40;
  localparam int SPLIT_W = 20;
  localparam int PROD_W  = 64;
  localparam int P_W     = 32;
  localparam int TOUT_W  = 15;
  localparam int POUT_W  = 17;
  localparam int IDX_W   = 3;

  // Fixed constants of the compensation formula.
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_KNEE = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRES_MIN  = 1000;
  localparam int PRES_MAX  = 120000;

  typedef enum logic [IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } calib_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctl_t;

  // First-order results leaving the third stage.
  typedef struct packed {
    logic signed [TEMP1_W-1:0] temp1;
    logic signed [OFF_W-1:0]   off1;
    logic signed [SENS_W-1:0]  sens1;
    logic [T2_W-1:0]           t2;
    logic [RAW_W-1:0]          d1;
  } first_t;

  // Corrected values leaving the sixth stage.
  typedef struct packed {
    logic signed [TEMP2_W-1:0] temp2;
    logic signed [OFF_W-1:0]   off;
    logic signed [SENS_W-1:0]  sens;
    logic [RAW_W-1:0]          d1;
  } second_t;

endpackage

FILE: sv/bpc_cfg_regs.sv
// Calibration register file of the barometric pressure compensation block.
// Depends on bpc_pkg for the register indexes and the calibration type.
module bpc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [bpc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]    cfg_data,
  output bpc_pkg::calib_t              calib
);
  import bpc_pkg::*;

  calib_t calib_next;

  always_comb begin
    calib_next = calib;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRESSURE_SENSITIVITY:   calib_next.pressure_sensitivity   = cfg_data;
        REG_PRESSURE_OFFSET:        calib_next.pressure_offset        = cfg_data;
        REG_SENSITIVITY_TEMP_COEFF: calib_next.sensitivity_temp_coeff = cfg_data;
        REG_OFFSET_TEMP_COEFF:      calib_next.offset_temp_coeff      = cfg_data;
        REG_REFERENCE_TEMPERATURE:  calib_next.reference_temperature  = cfg_data;
        REG_TEMPERATURE_COEFF:      calib_next.temperature_coeff      = cfg_data;
        default:                    calib_next = calib;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib <= '0;
    end else begin
      calib <= calib_next;
    end
  end

endmodule

FILE: sv/bpc_pipe_ctrl.sv
// Valid and stall control for the compensation pipeline.
// Depends on bpc_pkg for the stage count and the load vector type.
module bpc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                meas_valid,
  output logic                meas_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output bpc_pkg::stage_ctl_t ctl
);
  import bpc_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES-1:0] upstream;
  logic [NUM_STAGES:0]   adv;

  // A stage loads when it is empty or when the stage after it moves on,
  // so bubbles are squeezed out while the output stalls.
  assign adv[NUM_STAGES] = res_ready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
    assign adv[k] = ~vld[k] | adv[k+1];
  end

  assign upstream = {vld[NUM_STAGES-2:0], meas_valid};
  assign vld_next = (adv[NUM_STAGES-1:0] & upstream) | (~adv[NUM_STAGES-1:0] & vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ctl.load   = adv[NUM_STAGES-1:0];
  assign meas_ready = adv[0];
  assign res_valid  = vld[NUM_STAGES-1];

endmodule

FILE: sv/bpc_first_order.sv
// First-order compensation: dT, then TEMP, OFF, SENS and T2 over three stages.
// Depends on bpc_pkg for the calibration, control and result types.
module bpc_first_order (
  input  logic                         clk,
  input  bpc_pkg::stage_ctl_t          ctl,
  input  bpc_pkg::calib_t              calib,
  input  logic [bpc_pkg::RAW_W-1:0]    raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]    raw_temperature,
  output bpc_pkg::first_t              fo
);
  import bpc_pkg::*;

  // Stage one: temperature difference to the reference.
  logic signed [DT_W-1:0] dt_next;
  logic signed [DT_W-1:0] s1_dt;
  logic [RAW_W-1:0]       s1_d1;

  assign dt_next = $signed({1'b0, raw_temperature})
                 - $signed({1'b0, calib.reference_temperature, 8'h00});

  always_ff @(posedge clk) begin
    if (ctl.load[STG_DT]) begin
      s1_dt <= dt_next;
      s1_d1 <= raw_pressure;
    end
  end

  // Stage two: the four products of dT.
  logic signed [DT_W+CAL_W:0]  tc_next;
  logic signed [DT_W+CAL_W:0]  offp_next;
  logic signed [DT_W+CAL_W:0]  sensp_next;
  logic signed [2*DT_W-1:0]    dd_next;
  logic signed [DT_W+CAL_W:0]  s2_tc;
  logic signed [DT_W+CAL_W:0]  s2_offp;
  logic signed [DT_W+CAL_W:0]  s2_sensp;
  logic signed [2*DT_W-1:0]    s2_dd;
  logic [RAW_W-1:0]            s2_d1;

  assign tc_next    = s1_dt * $signed({1'b0, calib.temperature_coeff});
  assign offp_next  = s1_dt * $signed({1'b0, calib.offset_temp_coeff});
  assign sensp_next = s1_dt * $signed({1'b0, calib.sensitivity_temp_coeff});
  assign dd_next    = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (ctl.load[STG_MUL1]) begin
      s2_tc    <= tc_next;
      s2_offp  <= offp_next;
      s2_sensp <= sensp_next;
      s2_dd    <= dd_next;
      s2_d1    <= s1_d1;
    end
  end

  // Stage three: scale and add the calibration bases.
  first_t fo_next;

  always_comb begin
    fo_next.temp1 = TEMP1_W'(TEMP_REF + (s2_tc >>> 23));
    fo_next.off1  = OFF_W'($signed({1'b0, calib.pressure_offset, 16'h0000}))
                  + OFF_W'(s2_offp >>> 7);
    fo_next.sens1 = SENS_W'($signed({1'b0, calib.pressure_sensitivity, 15'h0000}))
                  + SENS_W'(s2_sensp >>> 8);
    fo_next.t2    = s2_dd[31+T2_W-1:31];
    fo_next.d1    = s2_d1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_FIRST]) begin
      fo <= fo_next;
    end
  end

endmodule

FILE: sv/bpc_second_order.sv
// Low-temperature correction: squares, correction terms and their application.
// Depends on bpc_pkg for the control and intermediate result types.
module bpc_second_order (
  input  logic                clk,
  input  bpc_pkg::stage_ctl_t ctl,
  input  bpc_pkg::first_t     fo,
  output bpc_pkg::second_t    so
);
  import bpc_pkg::*;

  // Stage four: squared distances from the two temperature knees.
  logic signed [TEMP2_W-1:0]   diff_ref;
  logic signed [TEMP2_W-1:0]   diff_knee;
  logic signed [2*TEMP2_W-1:0] sq_full;
  logic signed [2*TEMP2_W-1:0] sq2_full;
  logic [SQ_W-1:0]             s4_sq;
  logic [SQ_W-1:0]             s4_sq2;
  logic                        s4_low;
  logic                        s4_vlow;
  first_t                      s4;

  assign diff_ref  = TEMP2_W'(fo.temp1) - TEMP2_W'(TEMP_REF);
  assign diff_knee = TEMP2_W'(fo.temp1) - TEMP2_W'(TEMP_KNEE);
  assign sq_full   = diff_ref * diff_ref;
  assign sq2_full  = diff_knee * diff_knee;

  always_ff @(posedge clk) begin
    if (ctl.load[STG_SQUARE]) begin
      s4_sq   <= sq_full[SQ_W-1:0];
      s4_sq2  <= sq2_full[SQ_W-1:0];
      s4_low  <= fo.temp1 < TEMP1_W'(TEMP_REF);
      s4_vlow <= fo.temp1 < TEMP1_W'(TEMP_KNEE);
      s4      <= fo;
    end
  end

  // Stage five: correction terms by shift and add; zero above the first knee.
  logic [OFF_W-1:0]          five_sq;
  logic [OFF_W-1:0]          seven_sq2;
  logic [OFF_W-1:0]          eleven_sq2;
  logic [OFF_W-1:0]          off2_sum;
  logic [OFF_W-1:0]          sens2_sum;
  logic [CORR_W-1:0]         s5_off2;
  logic [CORR_W-1:0]         s5_sens2;
  logic signed [TEMP2_W-1:0] temp2_next;
  logic signed [TEMP2_W-1:0] s5_temp2;
  logic signed [OFF_W-1:0]   s5_off1;
  logic signed [SENS_W-1:0]  s5_sens1;
  logic [RAW_W-1:0]          s5_d1;

  always_comb begin
    five_sq    = (OFF_W'(s4_sq) << 2) + OFF_W'(s4_sq);
    seven_sq2  = (OFF_W'(s4_sq2) << 3) - OFF_W'(s4_sq2);
    eleven_sq2 = (OFF_W'(s4_sq2) << 3) + (OFF_W'(s4_sq2) << 1) + OFF_W'(s4_sq2);
    off2_sum   = (five_sq >> 1) + (s4_vlow ? seven_sq2 : '0);
    sens2_sum  = (five_sq >> 2) + (s4_vlow ? (eleven_sq2 >> 1) : '0);
    if (s4_low) begin
      temp2_next = TEMP2_W'(s4.temp1) - $signed({2'b00, s4.t2});
    end else begin
      temp2_next = TEMP2_W'(s4.temp1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_CORR]) begin
      s5_off2  <= s4_low ? off2_sum[CORR_W-1:0] : '0;
      s5_sens2 <= s4_low ? sens2_sum[CORR_W-1:0] : '0;
      s5_temp2 <= temp2_next;
      s5_off1  <= s4.off1;
      s5_sens1 <= s4.sens1;
      s5_d1    <= s4.d1;
    end
  end

  // Stage six: subtract the corrections from offset and sensitivity.
  second_t so_next;

  always_comb begin
    so_next.temp2 = s5_temp2;
    so_next.off   = s5_off1 - $signed({2'b00, s5_off2});
    so_next.sens  = s5_sens1 - $signed({2'b00, s5_sens2});
    so_next.d1    = s5_d1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_APPLY]) begin
      so <= so_next;
    end
  end

endmodule

FILE: sv/bpc_pressure.sv
// Pressure product, final scaling and saturation of both results.
// Depends on bpc_pkg for the control and intermediate result types.
module bpc_pressure (
  input  logic                               clk,
  input  bpc_pkg::stage_ctl_t                ctl,
  input  bpc_pkg::second_t                   so,
  output logic signed [bpc_pkg::TOUT_W-1:0]  temperature,
  output logic [bpc_pkg::POUT_W-1:0]         pressure,
  output logic                               clamped
);
  import bpc_pkg::*;

  // Stage seven: D1 times SENS as two partial products.
  logic [RAW_W+SPLIT_W-1:0]          pl_next;
  logic signed [RAW_W+SPLIT_W:0]     ph_next;
  logic [RAW_W+SPLIT_W-1:0]          s7_pl;
  logic signed [RAW_W+SPLIT_W:0]     s7_ph;
  logic signed [OFF_W-1:0]           s7_off;
  logic signed [TEMP2_W-1:0]         s7_temp2;

  assign pl_next = so.d1 * so.sens[SPLIT_W-1:0];
  assign ph_next = $signed({1'b0, so.d1}) * $signed(so.sens[SENS_W-1:SPLIT_W]);

  always_ff @(posedge clk) begin
    if (ctl.load[STG_PPROD]) begin
      s7_pl    <= pl_next;
      s7_ph    <= ph_next;
      s7_off   <= so.off;
      s7_temp2 <= so.temp2;
    end
  end

  // Stage eight: join the partial products.
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  s8_prod;
  logic signed [OFF_W-1:0]   s8_off;
  logic signed [TEMP2_W-1:0] s8_temp2;

  assign prod_next = (PROD_W'(s7_ph) <<< SPLIT_W) + $signed(PROD_W'(s7_pl));

  always_ff @(posedge clk) begin
    if (ctl.load[STG_PSUM]) begin
      s8_prod  <= prod_next;
      s8_off   <= s7_off;
      s8_temp2 <= s7_temp2;
    end
  end

  // Stage nine: P = (D1*SENS/2^21 - OFF)/2^15, shifts rounding down.
  logic signed [PROD_W-1:0]  diff;
  logic signed [P_W-1:0]     s9_p;
  logic signed [TEMP2_W-1:0] s9_temp2;

  assign diff = (s8_prod >>> 21) - PROD_W'(s8_off);

  always_ff @(posedge clk) begin
    if (ctl.load[STG_PRES]) begin
      s9_p     <= P_W'(diff >>> 15);
      s9_temp2 <= s8_temp2;
    end
  end

  // Stage ten: saturate into the reported ranges; this is the result register.
  logic signed [TEMP2_W-1:0] temp_sat;
  logic signed [P_W-1:0]     pres_sat;
  logic                      clamp_next;

  always_comb begin
    temp_sat   = s9_temp2;
    pres_sat   = s9_p;
    clamp_next = 1'b0;
    if (s9_temp2 < TEMP2_W'(TEMP_MIN)) begin
      temp_sat   = TEMP2_W'(TEMP_MIN);
      clamp_next = 1'b1;
    end
    if (s9_temp2 > TEMP2_W'(TEMP_MAX)) begin
      temp_sat   = TEMP2_W'(TEMP_MAX);
      clamp_next = 1'b1;
    end
    if (s9_p < P_W'(PRES_MIN)) begin
      pres_sat   = P_W'(PRES_MIN);
      clamp_next = 1'b1;
    end
    if (s9_p > P_W'(PRES_MAX)) begin
      pres_sat   = P_W'(PRES_MAX);
      clamp_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_CLAMP]) begin
      temperature <= temp_sat[TOUT_W-1:0];
      pressure    <= pres_sat[POUT_W-1:0];
      clamped     <= clamp_next;
    end
  end

endmodule

FILE: sv/barometric_pressure_compensation.sv
// Barometric pressure compensation, top level.
// Depends on bpc_pkg and on bpc_cfg_regs, bpc_pipe_ctrl, bpc_first_order,
// bpc_second_order and bpc_pressure.
//
// Each measurement transaction carries one raw 24-bit pressure conversion and
// one raw 24-bit temperature conversion. The block applies the standard
// second-order integer compensation with the six calibration words held in
// its registers and returns one result transaction: temperature in 0.01 degC
// saturated to -4000..8500, pressure in 0.01 mbar saturated to 1000..120000,
// and a clamped flag that is set when either value was saturated. Every
// division by a power of two rounds toward minus infinity. The datapath is a
// ten-stage pipeline that accepts one transaction per clock cycle while the
// result side does not hold it back. Each of the ten register stages holds at
// most one layer of multipliers or one wide add and compare. When the result
// side stalls, empty stages still fill, so up to ten transactions can be in
// flight and nothing is dropped. The calibration registers reset to zero and
// are written through the cfg port, which is always ready; indexes 0 to 5
// select pressure_sensitivity, pressure_offset, sensitivity_temp_coeff,
// offset_temp_coeff, reference_temperature and temperature_coeff, and writes
// to other indexes are ignored. Write calibration only while no transaction
// is in flight.
module barometric_pressure_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bpc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]          cfg_data,
  input  logic                               meas_valid,
  output logic                               meas_ready,
  input  logic [bpc_pkg::RAW_W-1:0]          raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]          raw_temperature,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [bpc_pkg::TOUT_W-1:0]  temperature,
  output logic [bpc_pkg::POUT_W-1:0]         pressure,
  output logic                               clamped
);
  import bpc_pkg::*;

  calib_t     calib;
  stage_ctl_t ctl;
  first_t     fo;
  second_t    so;

  // Register writes complete in the cycle they are presented.
  assign cfg_ready = 1'b1;

  bpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .calib     (calib)
  );

  // Stage valid bits and per-stage load enables for the whole datapath.
  bpc_pipe_ctrl u_pipe_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .ctl        (ctl)
  );

  // Stages one to three: dT and the first-order TEMP, OFF and SENS.
  bpc_first_order u_first_order (
    .clk             (clk),
    .ctl             (ctl),
    .calib           (calib),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .fo              (fo)
  );

  // Stages four to six: the low-temperature correction.
  bpc_second_order u_second_order (
    .clk (clk),
    .ctl (ctl),
    .fo  (fo),
    .so  (so)
  );

  // Stages seven to ten: pressure and saturation into the result register.
  bpc_pressure u_pressure (
    .clk         (clk),
    .ctl         (ctl),
    .so          (so),
    .temperature (temperature),
    .pressure    (pressure),
    .clamped     (clamped)
  );

endmodule

FILE: sim/tb_barometric_pressure_compensation.sv
// Testbench for barometric_pressure_compensation: random and directed conversions
// checked against a second-order compensation predictor. Depends on bpc_pkg
// and the barometric_pressure_compensation RTL.
module tb_barometric_pressure_compensation;
  import bpc_pkg::*;

  // The run is cut off at this cycle count.
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 36;
  localparam int PHASE_ITEMS = 290;

  // Register indexes past the last calibration word; writes there must be dropped.
  localparam logic [IDX_W-1:0] UNUSED_REG_LO = 3'd6;
  localparam logic [IDX_W-1:0] UNUSED_REG_HI = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } conversion_t;

  typedef struct packed {
    logic signed [TOUT_W-1:0] temperature;
    logic [POUT_W-1:0]        pressure;
    logic                     clamped;
  } reading_t;

  // Typical factory calibration; jittered copies of it keep most readings in range.
  localparam calib_t TYPICAL_CAL = '{
    pressure_sensitivity:   16'd40127,
    pressure_offset:        16'd36924,
    sensitivity_temp_coeff: 16'd23317,
    offset_temp_coeff:      16'd23282,
    reference_temperature:  16'd33464,
    temperature_coeff:      16'd28312
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CAL_W-1:0]         cfg_data = '0;
  logic                     meas_valid = 1'b0;
  logic                     meas_ready;
  logic [RAW_W-1:0]         raw_pressure = '0;
  logic [RAW_W-1:0]         raw_temperature = '0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  logic signed [TOUT_W-1:0] temperature;
  logic [POUT_W-1:0]        pressure;
  logic                     clamped;

  barometric_pressure_compensation uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .meas_valid      (meas_valid),
    .meas_ready      (meas_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .temperature     (temperature),
    .pressure        (pressure),
    .clamped         (clamped)
  );

  initial forever #4 clk = ~clk;

  // Conversions waiting to be driven, and readings predicted for accepted ones.
  conversion_t pending_conversions[$];
  reading_t    expected_readings[$];
  conversion_t next_conv;
  reading_t    want;

  // Calibration as the block should hold it, updated on every accepted write.
  calib_t cal_shadow = '0;

  int  items_queued = 0;
  int  items_accepted = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  src_idle_pct = IDLE_PCT;
  int  sink_stall_pct = IDLE_PCT;
  int  d2_center = 0;
  bit  meas_taken = 1'b0;

  // Second-order compensation. All arithmetic is signed 64-bit, and every shift
  // right is arithmetic, so each division by a power of two floors.
  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw);
    longint   d1, dt, temp_c, off, sens, t2, sq, sq2, off2, sens2, p;
    reading_t r;
    d1     = longint'(d1_raw);
    dt     = longint'(d2_raw) - longint'(cal_shadow.reference_temperature) * 256;
    temp_c = TEMP_REF + ((dt * longint'(cal_shadow.temperature_coeff)) >>> 23);
    off    = longint'(cal_shadow.pressure_offset) * 65536
           + ((longint'(cal_shadow.offset_temp_coeff) * dt) >>> 7);
    sens   = longint'(cal_shadow.pressure_sensitivity) * 32768
           + ((longint'(cal_shadow.sensitivity_temp_coeff) * dt) >>> 8);
    // Below 20 degC the low-temperature correction kicks in, and below
    // -15 degC a second, steeper term is stacked on top of it.
    if (temp_c < TEMP_REF) begin
      t2    = (dt * dt) >>> 31;
      sq    = (temp_c - TEMP_REF) * (temp_c - TEMP_REF);
      off2  = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp_c < TEMP_KNEE) begin
        sq2   = (temp_c - TEMP_KNEE) * (temp_c - TEMP_KNEE);
        off2  = off2 + 7 * sq2;
        sens2 = sens2 + ((11 * sq2) >>> 1);
      end
      temp_c = temp_c - t2;
      off    = off - off2;
      sens   = sens - sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.clamped = 1'b0;
    if (temp_c < TEMP_MIN) begin
      temp_c = TEMP_MIN;
      r.clamped = 1'b1;
    end
    if (temp_c > TEMP_MAX) begin
      temp_c = TEMP_MAX;
      r.clamped = 1'b1;
    end
    if (p < PRES_MIN) begin
      p = PRES_MIN;
      r.clamped = 1'b1;
    end
    if (p > PRES_MAX) begin
      p = PRES_MAX;
      r.clamped = 1'b1;
    end
    r.temperature = temp_c[TOUT_W-1:0];
    r.pressure    = p[POUT_W-1:0];
    return r;
  endfunction

  function automatic logic [CAL_W-1:0] jitter_word(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[CAL_W-1:0];
  endfunction

  // Most conversions sit in the span a real sensor produces around the
  // reference temperature, which reaches both cold corrections; the rest are
  // fully random and mostly saturate.
  function automatic conversion_t random_conversion(input int d2_mid);
    conversion_t c;
    int          d2;
    if ($urandom_range(99) < 65) begin
      c.raw_pressure = RAW_W'($urandom_range(12000000, 4000000));
      d2 = d2_mid + int'($urandom_range(8000000)) - 4000000;
      if (d2 < 0) d2 = 0;
      if (d2 > 16777215) d2 = 16777215;
      c.raw_temperature = d2[RAW_W-1:0];
    end else begin
      c.raw_pressure    = RAW_W'($urandom);
      c.raw_temperature = RAW_W'($urandom);
    end
    return c;
  endfunction

  task automatic queue_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    pending_conversions.push_back('{raw_pressure: d1, raw_temperature: d2});
    items_queued++;
  endtask

  // Calibration writes go out one transaction at a time from the falling edge.
  task automatic write_calib(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes all six words, then one to an unused index that must change nothing.
  task automatic program_calibration(input calib_t c);
    write_calib(REG_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
    write_calib(REG_PRESSURE_OFFSET, c.pressure_offset);
    write_calib(REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
    write_calib(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
    write_calib(REG_REFERENCE_TEMPERATURE, c.reference_temperature);
    write_calib(REG_TEMPERATURE_COEFF, c.temperature_coeff);
    write_calib($urandom_range(1) ? UNUSED_REG_HI : UNUSED_REG_LO, CAL_W'($urandom));
    d2_center = int'(c.reference_temperature) * 256;
  endtask

  // The pipeline is empty once every queued conversion has been accepted and
  // every predicted reading has come back.
  task automatic wait_drained();
    while (items_accepted != items_queued || expected_readings.size() != 0)
      @(negedge clk);
  endtask

  // Measurement driver: a new transaction is offered only when the previous
  // one was taken at the last rising edge, so valid and payload hold steady
  // while the block stalls. The result side stalls at random on its own.
  always @(negedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
      res_ready  <= 1'b0;
    end else begin
      if (!meas_valid || meas_taken) begin
        if (pending_conversions.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          next_conv = pending_conversions.pop_front();
          meas_valid      <= 1'b1;
          raw_pressure    <= next_conv.raw_pressure;
          raw_temperature <= next_conv.raw_temperature;
        end else begin
          meas_valid <= 1'b0;
        end
      end
      res_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: tracks calibration writes, predicts a reading for each accepted
  // measurement and checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      cal_shadow = '0;
      meas_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESSURE_SENSITIVITY:   cal_shadow.pressure_sensitivity = cfg_data;
          REG_PRESSURE_OFFSET:        cal_shadow.pressure_offset = cfg_data;
          REG_SENSITIVITY_TEMP_COEFF: cal_shadow.sensitivity_temp_coeff = cfg_data;
          REG_OFFSET_TEMP_COEFF:      cal_shadow.offset_temp_coeff = cfg_data;
          REG_REFERENCE_TEMPERATURE:  cal_shadow.reference_temperature = cfg_data;
          REG_TEMPERATURE_COEFF:      cal_shadow.temperature_coeff = cfg_data;
          default: ;
        endcase
      end
      meas_taken = meas_valid && meas_ready;
      if (meas_taken) begin
        expected_readings.push_back(compensate(raw_pressure, raw_temperature));
        items_accepted++;
      end
      if (res_valid && res_ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result: temperature %0d pressure %0d clamped %0b",
                 temperature, pressure, clamped);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (temperature !== want.temperature) begin
            $error("temperature: expected %0d, got %0d", want.temperature, temperature);
            mismatches++;
          end
          if (pressure !== want.pressure) begin
            $error("pressure: expected %0d, got %0d", want.pressure, pressure);
            mismatches++;
          end
          if (clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, clamped);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    calib_t      cal;
    conversion_t conv;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Calibration still all zero after reset: the arithmetic runs as usual
    // and pressure ends up pinned at its lower bound.
    queue_conversion('0, '0);
    queue_conversion('1, '1);
    queue_conversion('1, '0);
    wait_drained();

    // Typical calibration across the temperature range: the reference point,
    // exactly 20 degC, the mild and the steep cold corrections around the
    // -15 degC knee, and both saturating extremes of the raw fields.
    program_calibration(TYPICAL_CAL);
    queue_conversion(24'd9085466, 24'd8569150);
    queue_conversion(24'd9085466, 24'(d2_center));
    queue_conversion(24'd9085466, 24'(d2_center - 300000));
    queue_conversion(24'd9085466, 24'(d2_center - 1037020));
    queue_conversion(24'd9085466, 24'(d2_center - 1037021));
    queue_conversion(24'd9085466, 24'(d2_center - 1500000));
    queue_conversion(24'd9085466, 24'(d2_center + 500000));
    queue_conversion(24'd9085466, '0);
    queue_conversion(24'd9085466, '1);
    queue_conversion('0, 24'd8569150);
    queue_conversion('1, 24'd8569150);
    wait_drained();

    // Every calibration word at its maximum.
    program_calibration('1);
    queue_conversion('0, '0);
    queue_conversion('1, '1);
    queue_conversion('1, '0);
    queue_conversion('0, '1);
    wait_drained();

    // Both unused indexes written with zero; the maximum calibration must stay.
    write_calib(UNUSED_REG_LO, '0);
    write_calib(UNUSED_REG_HI, '0);
    queue_conversion('1, '1);
    queue_conversion(24'd9085466, 24'd8569150);
    wait_drained();

    // Random phases, each with its own calibration. The middle phase runs
    // with no idling on either side; the last uses fully random words.
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      if (phase == 2) begin
        cal = TYPICAL_CAL;
      end else if (phase == 4) begin
        cal = calib_t'({$urandom, $urandom, $urandom});
      end else begin
        cal.pressure_sensitivity   = jitter_word(int'(TYPICAL_CAL.pressure_sensitivity), 8000);
        cal.pressure_offset        = jitter_word(int'(TYPICAL_CAL.pressure_offset), 8000);
        cal.sensitivity_temp_coeff = jitter_word(int'(TYPICAL_CAL.sensitivity_temp_coeff), 8000);
        cal.offset_temp_coeff      = jitter_word(int'(TYPICAL_CAL.offset_temp_coeff), 8000);
        cal.reference_temperature  = jitter_word(int'(TYPICAL_CAL.reference_temperature), 4000);
        cal.temperature_coeff      = jitter_word(int'(TYPICAL_CAL.temperature_coeff), 8000);
      end
      program_calibration(cal);
      src_idle_pct   = (phase == 2) ? 0 : IDLE_PCT;
      sink_stall_pct = (phase == 2) ? 0 : IDLE_PCT;
      repeat (PHASE_ITEMS) begin
        conv = random_conversion(d2_center);
        queue_conversion(conv.raw_pressure, conv.raw_temperature);
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    wait_drained();
    repeat (3 * NUM_STAGES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
